>>> sv/round_robin_thread_slot_scheduler_macros.svh
// Assertion macros for the round-robin thread slot scheduler.
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define RRTS_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scheduler assertion failed");
`define RRTS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("scheduler assertion failed");
`else
`define RRTS_ASSERT_HOLD(lbl, cond)
`define RRTS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> sv/rrts_pkg.sv
// Shared types, constants and helpers of the round-robin thread slot scheduler.
`default_nettype none
package rrts_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int FRAME_BYTES = 48;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int IDX_W       = 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_CREATE    = 2'd0;
  localparam logic [1:0] OP_START     = 2'd1;
  localparam logic [1:0] OP_YIELD     = 2'd2;
  localparam logic [1:0] OP_TERMINATE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_THREAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_CREATE,
    K_START,
    K_YIELD,
    K_TERMINATE
  } op_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] stack_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [31:0]      run_stack;
  } out_word_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Lowest clear bit of the used mask; zero when none is clear.
  function automatic logic [SLOT_W-1:0] first_free(input logic [SLOT_COUNT-1:0] used);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (!used[k]) idx = SLOT_W'(k);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

>>> sv/rrts_front.sv
// Front end: accept request words and classify them into commands.
`default_nettype none
module rrts_front (
  input  wire                 start,
  input  rrts_pkg::in_word_t  request,
  input  rrts_pkg::q_stat_t   q_stat,
  output logic                busy,
  output logic                push,
  output rrts_pkg::cmd_t      cmd
);

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  // Decode the opcode; precompute the initial stack pointer for create.
  always_comb begin
    cmd.value = request.stack_value;
    case (request.opcode)
      rrts_pkg::OP_CREATE: begin
        cmd.kind  = rrts_pkg::K_CREATE;
        cmd.value = request.stack_value - 32'(rrts_pkg::FRAME_BYTES);
      end
      rrts_pkg::OP_START:     cmd.kind = rrts_pkg::K_START;
      rrts_pkg::OP_YIELD:     cmd.kind = rrts_pkg::K_YIELD;
      rrts_pkg::OP_TERMINATE: cmd.kind = rrts_pkg::K_TERMINATE;
      default:                cmd.kind = rrts_pkg::K_START;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/rrts_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module rrts_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  rrts_pkg::cmd_t     push_cmd,
  input  wire                pop,
  output rrts_pkg::cmd_t     head_cmd,
  output rrts_pkg::q_stat_t  q_stat
);

  rrts_pkg::cmd_t entries [rrts_pkg::Q_DEPTH];
  logic [rrts_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [rrts_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [rrts_pkg::Q_CNT_W-1:0] count;

  function automatic logic [rrts_pkg::Q_PTR_W-1:0] bump(input logic [rrts_pkg::Q_PTR_W-1:0] p);
    return (p == rrts_pkg::Q_PTR_W'(rrts_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_cmd     = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == rrts_pkg::Q_CNT_W'(rrts_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/rrts_back.sv
// Back end: slot state, ring link and stack memories, and the command sequencer.
`default_nettype none
module rrts_back (
  input  wire                 clk,
  input  wire                 rst,
  input  rrts_pkg::cmd_t      cmd,
  input  rrts_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                done,
  output rrts_pkg::out_word_t result
);

  localparam int SW = rrts_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLINK,
    S_CLINK2,
    S_YNEXT,
    S_RESUME,
    S_TCUR,
    S_TWALK,
    S_TFIN
  } state_t;

  state_t state;
  logic [rrts_pkg::SLOT_COUNT-1:0] slot_used;
  logic [SW-1:0] head_slot;
  logic          ring_empty;
  logic [SW-1:0] current_slot;
  logic [SW-1:0] new_slot;
  logic [SW-1:0] cur_next;
  logic [SW-1:0] walk_p;
  logic [31:0]   frame;

  logic [SW-1:0] ring_mem  [rrts_pkg::SLOT_COUNT];
  logic [31:0]   stack_mem [rrts_pkg::SLOT_COUNT];
  logic [SW-1:0] ring_rdata;
  logic [31:0]   stack_rdata;

  logic          ring_we;
  logic [SW-1:0] ring_wa;
  logic [SW-1:0] ring_wd;
  logic [SW-1:0] ring_ra;
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [31:0]   stk_wd;
  logic [SW-1:0] stk_ra;

  logic          free_any;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] fin_head;

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign free_any = ~&slot_used;
  assign free_idx = rrts_pkg::first_free(slot_used);
  assign fin_head = (head_slot == current_slot) ? cur_next : head_slot;

  // Memory port steering.
  always_comb begin
    ring_we = 1'b0;
    ring_wa = '0;
    ring_wd = '0;
    ring_ra = '0;
    stk_we  = 1'b0;
    stk_wa  = '0;
    stk_wd  = '0;
    stk_ra  = '0;
    case (state)
      S_IDLE: begin
        if (pop) begin
          if (cmd.kind == rrts_pkg::K_CREATE) begin
            if (free_any) begin
              stk_we = 1'b1;
              stk_wa = free_idx;
              stk_wd = cmd.value;
              if (ring_empty) begin
                ring_we = 1'b1;
                ring_wa = free_idx;
                ring_wd = free_idx;
              end else begin
                ring_ra = head_slot;
              end
            end
          end else if (!ring_empty) begin
            if (cmd.kind == rrts_pkg::K_START || !slot_used[current_slot]) begin
              stk_ra = head_slot;
            end else if (cmd.kind == rrts_pkg::K_YIELD) begin
              stk_we  = 1'b1;
              stk_wa  = current_slot;
              stk_wd  = cmd.value;
              ring_ra = current_slot;
            end else begin
              ring_ra = current_slot;
            end
          end
        end
      end
      S_CLINK: begin
        ring_we = 1'b1;
        ring_wa = new_slot;
        ring_wd = ring_rdata;
      end
      S_CLINK2: begin
        ring_we = 1'b1;
        ring_wa = head_slot;
        ring_wd = new_slot;
      end
      S_YNEXT: stk_ra = ring_rdata;
      S_TCUR:  ring_ra = head_slot;
      S_TWALK: begin
        if (ring_rdata == current_slot) begin
          ring_we = 1'b1;
          ring_wa = walk_p;
          ring_wd = cur_next;
        end else begin
          ring_ra = ring_rdata;
        end
      end
      S_TFIN:  stk_ra = fin_head;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rdata <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stack_rdata <= stack_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_used    <= '0;
      head_slot    <= '0;
      ring_empty   <= 1'b1;
      current_slot <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (cmd.kind == rrts_pkg::K_CREATE) begin
              if (!free_any) begin
                done              <= 1'b1;
                result.status     <= rrts_pkg::ST_NO_FREE;
                result.slot_index <= '0;
                result.run_stack  <= '0;
              end else begin
                slot_used[free_idx] <= 1'b1;
                new_slot            <= free_idx;
                frame               <= cmd.value;
                if (ring_empty) begin
                  head_slot         <= free_idx;
                  ring_empty        <= 1'b0;
                  done              <= 1'b1;
                  result.status     <= rrts_pkg::ST_OK;
                  result.slot_index <= rrts_pkg::IDX_W'(free_idx);
                  result.run_stack  <= cmd.value;
                end else begin
                  state <= S_CLINK;
                end
              end
            end else if (ring_empty) begin
              done              <= 1'b1;
              result.status     <= rrts_pkg::ST_NO_THREAD;
              result.slot_index <= '0;
              result.run_stack  <= '0;
            end else if (cmd.kind == rrts_pkg::K_START || !slot_used[current_slot]) begin
              current_slot <= head_slot;
              state        <= S_RESUME;
            end else if (cmd.kind == rrts_pkg::K_YIELD) begin
              state <= S_YNEXT;
            end else begin
              state <= S_TCUR;
            end
          end
        end
        S_CLINK: state <= S_CLINK2;
        S_CLINK2: begin
          done              <= 1'b1;
          result.status     <= rrts_pkg::ST_OK;
          result.slot_index <= rrts_pkg::IDX_W'(new_slot);
          result.run_stack  <= frame;
          state             <= S_IDLE;
        end
        S_YNEXT: begin
          current_slot <= ring_rdata;
          state        <= S_RESUME;
        end
        S_RESUME: begin
          done              <= 1'b1;
          result.status     <= rrts_pkg::ST_OK;
          result.slot_index <= rrts_pkg::IDX_W'(current_slot);
          result.run_stack  <= stack_rdata;
          state             <= S_IDLE;
        end
        S_TCUR: begin
          cur_next <= ring_rdata;
          walk_p   <= head_slot;
          state    <= S_TWALK;
        end
        S_TWALK: begin
          if (ring_rdata == current_slot) begin
            state <= S_TFIN;
          end else begin
            walk_p <= ring_rdata;
          end
        end
        S_TFIN: begin
          slot_used[current_slot] <= 1'b0;
          if (head_slot == current_slot && cur_next == current_slot) begin
            head_slot         <= '0;
            ring_empty        <= 1'b1;
            done              <= 1'b1;
            result.status     <= rrts_pkg::ST_NO_THREAD;
            result.slot_index <= '0;
            result.run_stack  <= '0;
            state             <= S_IDLE;
          end else begin
            head_slot    <= fin_head;
            current_slot <= fin_head;
            state        <= S_RESUME;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/round_robin_thread_slot_scheduler.sv
// Top level of the round-robin thread slot scheduler.
`default_nettype none
`include "round_robin_thread_slot_scheduler_macros.svh"
// A request word is taken on a clock edge with start high and busy low; a
// two-entry command queue parts the decoding front end from the back end, so
// busy rises only while that queue is full. Each result word shows on result
// for exactly one cycle with done high, and the receiver cannot stall it, so
// the caller must capture it on that edge. A create into an empty ring, a
// create that finds no free slot and any other word on an empty ring finish
// straight from idle; create into a non-empty ring goes through S_CLINK and
// S_CLINK2, start (as do yield and terminate from a slot no longer in use)
// through S_RESUME, yield through S_YNEXT and S_RESUME, and terminate through
// S_TCUR, S_TWALK (walking links from the head to the predecessor of the
// running slot, up to SLOT_COUNT - 1 of them), S_TFIN and S_RESUME, or ends
// at S_TFIN when it frees the last thread. The registered single-read-port
// ring link memory walks one link per cycle. Words run in acceptance order.
module round_robin_thread_slot_scheduler (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  rrts_pkg::in_word_t   request,
  output logic                 busy,
  output logic                 done,
  output rrts_pkg::out_word_t  result
);

  logic               push;
  logic               pop;
  rrts_pkg::cmd_t     push_cmd;
  rrts_pkg::cmd_t     head_cmd;
  rrts_pkg::q_stat_t  q_stat;
  logic               status_known;
  logic               fail_clear;

  // Decode the request word and push it while the queue has room.
  rrts_front u_front (
    .start   (start),
    .request (request),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .cmd     (push_cmd)
  );

  // Hold accepted commands until the back end is free.
  rrts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Execute commands against the slot ring and strobe out one result each.
  rrts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (head_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  assign status_known = result.status == rrts_pkg::ST_OK ||
                        result.status == rrts_pkg::ST_NO_FREE ||
                        result.status == rrts_pkg::ST_NO_THREAD;
  assign fail_clear   = result.slot_index == '0 && result.run_stack == '0;

  // An accepted word must land in the queue.
  `RRTS_ASSERT_NEXT(a_accept_queued, start && !busy, !q_stat.empty)
  // Results carry only defined status codes.
  `RRTS_ASSERT_HOLD(a_status_code, !done || status_known)
  // A failed call never names a slot.
  `RRTS_ASSERT_HOLD(a_fail_zero, !done || result.status == rrts_pkg::ST_OK || fail_clear)

endmodule
`default_nettype wire
